### rtl/ahnl_pkg.sv
package ahnl_pkg;

    // tree depth: heap has 2^LEVEL slots
    localparam int LEVEL = 8;
    localparam int NODE_W = LEVEL;
    localparam int COORD_W = 16;
    localparam int INDEX_OUT_W = 8;
    localparam int REG_INDEX_W = 3;
    localparam int REG_DATA_W = 16;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COORD_W:0] wide_t;
    typedef logic [NODE_W-1:0] node_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_WORLD_MIN_X = 3'd0,
        REG_WORLD_MIN_Y = 3'd1,
        REG_WORLD_MIN_Z = 3'd2,
        REG_WORLD_MAX_X = 3'd3,
        REG_WORLD_MAX_Y = 3'd4,
        REG_WORLD_MAX_Z = 3'd5
    } reg_index_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    typedef struct packed {
        vec_t lo;
        vec_t hi;
    } box_t;

    typedef struct packed {
        coord_t query_min_x;
        coord_t query_min_y;
        coord_t query_min_z;
        coord_t query_max_x;
        coord_t query_max_y;
        coord_t query_max_z;
    } query_t;

    typedef struct packed {
        logic [INDEX_OUT_W-1:0] node_index;
        logic                   fits;
    } result_t;

    // state carried down the descent pipeline
    typedef struct packed {
        box_t  query;
        box_t  node_box;
        node_t node;
        logic  fits;
        logic  done;
    } stage_t;

    function automatic logic contains(input box_t nb, input box_t q);
        logic ok;
        ok = (nb.lo.x <= q.lo.x) && (nb.lo.y <= q.lo.y) && (nb.lo.z <= q.lo.z)
          && (nb.hi.x >= q.hi.x) && (nb.hi.y >= q.hi.y) && (nb.hi.z >= q.hi.z);
        return ok;
    endfunction

    function automatic coord_t vec_get(input vec_t v, input axis_t a);
        coord_t r;
        unique case (a)
            AXIS_X:  r = v.x;
            AXIS_Y:  r = v.y;
            AXIS_Z:  r = v.z;
            default: r = v.x;
        endcase
        return r;
    endfunction

    function automatic vec_t vec_set(input vec_t v, input axis_t a, input coord_t c);
        vec_t r;
        r = v;
        unique case (a)
            AXIS_X:  r.x = c;
            AXIS_Y:  r.y = c;
            AXIS_Z:  r.z = c;
            default: r.x = c;
        endcase
        return r;
    endfunction

endpackage

### rtl/ahnl_split_stage.sv
module ahnl_split_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  ahnl_pkg::stage_t in_stage,
    output logic            out_valid,
    output ahnl_pkg::stage_t out_stage
);
    import ahnl_pkg::*;

    logic   valid_reg;
    stage_t stage_reg;
    stage_t stage_next;

    wide_t  d_x;
    wide_t  d_y;
    wide_t  d_z;
    axis_t  axis;
    coord_t a_lo;
    coord_t a_hi;
    wide_t  mid_sum;
    coord_t centre;
    box_t   left_box;
    box_t   right_box;

    // signed side lengths pick the split axis, ties to x then y
    always_comb
    begin
        d_x = wide_t'(in_stage.node_box.hi.x) - wide_t'(in_stage.node_box.lo.x);
        d_y = wide_t'(in_stage.node_box.hi.y) - wide_t'(in_stage.node_box.lo.y);
        d_z = wide_t'(in_stage.node_box.hi.z) - wide_t'(in_stage.node_box.lo.z);
        priority if (d_x >= d_y && d_x >= d_z)
            axis = AXIS_X;
        else if (d_y >= d_z)
            axis = AXIS_Y;
        else
            axis = AXIS_Z;
    end

    // floor((lo+hi)/2) via arithmetic shift of the 17-bit sum
    always_comb
    begin
        a_lo    = vec_get(in_stage.node_box.lo, axis);
        a_hi    = vec_get(in_stage.node_box.hi, axis);
        mid_sum = wide_t'(a_lo) + wide_t'(a_hi);
        centre  = mid_sum[COORD_W:1];

        left_box     = in_stage.node_box;
        left_box.hi  = vec_set(in_stage.node_box.hi, axis, centre);
        right_box    = in_stage.node_box;
        right_box.lo = vec_set(in_stage.node_box.lo, axis, centre);
    end

    always_comb
    begin
        stage_next = in_stage;
        if (in_stage.fits && !in_stage.done)
        begin
            priority if (contains(left_box, in_stage.query))
            begin
                stage_next.node     = {in_stage.node[NODE_W-2:0], 1'b0};
                stage_next.node_box = left_box;
            end
            else if (contains(right_box, in_stage.query))
            begin
                stage_next.node     = {in_stage.node[NODE_W-2:0], 1'b1};
                stage_next.node_box = right_box;
            end
            else
            begin
                stage_next.done = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

    // a fitting request always sits in a node box that holds it
    a_fit_contained: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && stage_reg.fits |-> contains(stage_reg.node_box, stage_reg.query))
        else $error("node box does not hold the request box");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !stage_reg.fits |-> stage_reg.node == '0 && stage_reg.done)
        else $error("root miss carries a nonzero node");

    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stage.done |=> stage_reg.done && stage_reg.node == $past(in_stage.node))
        else $error("finished request moved on");

endmodule

### rtl/aabb_hierarchy_node_locate_core.sv
// Path: start is registered in the entry stage, then in each split stage in turn.
// Throughput: one request per cycle; busy stays low, start may be high every cycle.
// Depth: one entry stage for the root test plus one split stage per level below the root.
// The receiver cannot stall: each result shows for exactly one cycle with done.
// Reset (rst_n, async, active low) clears the valid bits in flight and loads
//   the world box with its full signed range.
module aabb_hierarchy_node_locate_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ahnl_pkg::query_t                    query,
    output logic                                done,
    output ahnl_pkg::result_t                   result,
    input  logic                                wr_en,
    input  logic [ahnl_pkg::REG_INDEX_W-1:0]    wr_index,
    input  logic [ahnl_pkg::REG_DATA_W-1:0]     wr_data
);
    import ahnl_pkg::*;

    box_t   world_reg;
    box_t   query_box;
    logic   accept;

    logic   entry_valid_reg;
    stage_t entry_reg;
    stage_t entry_next;

    // pipe[0] is the root entry stage; pipe[k] leaves level k of descent
    logic   pipe_valid [LEVEL];
    stage_t pipe       [LEVEL];

    // world box; write only while no request is in flight, which the block does not check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_reg.lo.x <= coord_t'(-32768);
            world_reg.lo.y <= coord_t'(-32768);
            world_reg.lo.z <= coord_t'(-32768);
            world_reg.hi.x <= coord_t'(32767);
            world_reg.hi.y <= coord_t'(32767);
            world_reg.hi.z <= coord_t'(32767);
        end
        else if (wr_en)
        begin
            unique case (reg_index_t'(wr_index))
                REG_WORLD_MIN_X: world_reg.lo.x <= coord_t'(wr_data);
                REG_WORLD_MIN_Y: world_reg.lo.y <= coord_t'(wr_data);
                REG_WORLD_MIN_Z: world_reg.lo.z <= coord_t'(wr_data);
                REG_WORLD_MAX_X: world_reg.hi.x <= coord_t'(wr_data);
                REG_WORLD_MAX_Y: world_reg.hi.y <= coord_t'(wr_data);
                REG_WORLD_MAX_Z: world_reg.hi.z <= coord_t'(wr_data);
                default:         ; // unknown index: ignored
            endcase
        end
    end

    // pipeline never blocks a request
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        query_box.lo.x = query.query_min_x;
        query_box.lo.y = query.query_min_y;
        query_box.lo.z = query.query_min_z;
        query_box.hi.x = query.query_max_x;
        query_box.hi.y = query.query_max_y;
        query_box.hi.z = query.query_max_z;
    end

    // root test: a miss is finished at once with node 0
    always_comb
    begin
        entry_next.query    = query_box;
        entry_next.node_box = world_reg;
        entry_next.fits     = contains(world_reg, query_box);
        entry_next.done     = !entry_next.fits;
        entry_next.node     = entry_next.fits ? node_t'(1) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_valid_reg <= 1'b0;
        else
            entry_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign pipe_valid[0] = entry_valid_reg;
    assign pipe[0]       = entry_reg;

    // one split stage per level below the root
    for (genvar k = 1; k < LEVEL; k++)
    begin : g_level
        ahnl_split_stage u_split (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[k-1]),
            .in_stage  (pipe[k-1]),
            .out_valid (pipe_valid[k]),
            .out_stage (pipe[k])
        );
    end

    // the whole heap index goes out, cast to INDEX_OUT_W bits
    assign done              = pipe_valid[LEVEL-1];
    assign result.node_index = INDEX_OUT_W'(pipe[LEVEL-1].node);
    assign result.fits       = pipe[LEVEL-1].fits;

endmodule

### sim/aabb_hierarchy_node_locate_core_test.sv
`timescale 1ns / 1ps

module aabb_hierarchy_node_locate_core_test;

    import ahnl_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 9;
    // pipeline depth plus margin, waited out before any register write
    localparam int DRAIN_CYCLES   = LEVEL + 4;
    // cycles with neither a request taken nor a result shown
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;
    localparam int COORD_MIN      = -32768;
    localparam int COORD_MAX      = 32767;

    // indexes past the register list; writes there must be dropped
    localparam logic [REG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [REG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    query_t                 query;
    logic                   done;
    result_t                result;
    logic                   wr_en;
    logic [REG_INDEX_W-1:0] wr_index;
    logic [REG_DATA_W-1:0]  wr_data;

    // predictor copy of the world box registers
    coord_t world_lo [3];
    coord_t world_hi [3];

    // node lookups still owed by the block, oldest first
    result_t pending_results [$];

    int mismatch_count;
    int idle_cycles;
    int burst_left;

    aabb_hierarchy_node_locate_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .query    (query),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // split axis: longest side, ties to x then y; sides are signed
    function automatic axis_t split_axis(input int dx, input int dy, input int dz);
        if (dx >= dy && dx >= dz)
            return AXIS_X;
        else if (dy >= dx && dy >= dz)
            return AXIS_Y;
        return AXIS_Z;
    endfunction

    // walk the implicit tree from the root; left child wins when both hold
    function automatic result_t locate_node(input query_t q);
        int          qlo [3];
        int          qhi [3];
        int          lo [3];
        int          hi [3];
        int          k;
        int          a;
        int          centre;
        int unsigned node;
        logic        hold_root;
        logic        hold_left;
        logic        hold_right;
        result_t     r;
        qlo[0] = q.query_min_x;
        qlo[1] = q.query_min_y;
        qlo[2] = q.query_min_z;
        qhi[0] = q.query_max_x;
        qhi[1] = q.query_max_y;
        qhi[2] = q.query_max_z;
        hold_root = 1'b1;
        for (k = 0; k < 3; k++)
        begin
            lo[k] = world_lo[k];
            hi[k] = world_hi[k];
            if (lo[k] > qlo[k] || hi[k] < qhi[k])
                hold_root = 1'b0;
        end
        r = '0;
        if (!hold_root)
            return r;
        node = 1;
        while (2 * node < (1 << LEVEL))
        begin
            a = int'(split_axis(hi[0] - lo[0], hi[1] - lo[1], hi[2] - lo[2]));
            // floor of the midpoint: arithmetic shift on a 32-bit sum
            centre = (lo[a] + hi[a]) >>> 1;
            hold_left  = 1'b1;
            hold_right = 1'b1;
            for (k = 0; k < 3; k++)
            begin
                if (lo[k] > qlo[k] || ((k == a) ? centre : hi[k]) < qhi[k])
                    hold_left = 1'b0;
                if (((k == a) ? centre : lo[k]) > qlo[k] || hi[k] < qhi[k])
                    hold_right = 1'b0;
            end
            if (hold_left)
            begin
                node  = 2 * node;
                hi[a] = centre;
            end
            else if (hold_right)
            begin
                node  = 2 * node + 1;
                lo[a] = centre;
            end
            else
                break;
        end
        r.node_index = node[INDEX_OUT_W-1:0];
        r.fits       = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------

    function automatic query_t make_query(input int lx, input int ly, input int lz,
                                          input int hx, input int hy, input int hz);
        query_t q;
        q.query_min_x = coord_t'(lx);
        q.query_min_y = coord_t'(ly);
        q.query_min_z = coord_t'(lz);
        q.query_max_x = coord_t'(hx);
        q.query_max_y = coord_t'(hy);
        q.query_max_z = coord_t'(hz);
        return q;
    endfunction

    // value in [a, b], leaning on the two ends so bounds get hit exactly
    function automatic int pick_between(input int a, input int b);
        int roll;
        roll = $urandom_range(0, 3);
        if (b <= a)
            return a;
        if (roll == 0)
            return a;
        if (roll == 1)
            return b;
        return a + int'($urandom_range(0, b - a));
    endfunction

    // box held by a randomly chosen node at a random depth; it may still
    // straddle that node's split, which ends the descent there
    function automatic query_t nested_query();
        int   lo [3];
        int   hi [3];
        int   qlo [3];
        int   qhi [3];
        int   k;
        int   a;
        int   centre;
        int   depth;
        logic skewed;
        skewed = 1'b0;
        for (k = 0; k < 3; k++)
        begin
            lo[k] = world_lo[k];
            hi[k] = world_hi[k];
            if (hi[k] < lo[k])
                skewed = 1'b1;
        end
        // an inverted world only holds inverted boxes; stay at the root
        depth = skewed ? 0 : $urandom_range(0, LEVEL - 1);
        repeat (depth)
        begin
            a = int'(split_axis(hi[0] - lo[0], hi[1] - lo[1], hi[2] - lo[2]));
            centre = (lo[a] + hi[a]) >>> 1;
            if ($urandom_range(0, 1))
                hi[a] = centre;
            else
                lo[a] = centre;
        end
        for (k = 0; k < 3; k++)
        begin
            if (hi[k] >= lo[k])
            begin
                qlo[k] = pick_between(lo[k], hi[k]);
                qhi[k] = pick_between(qlo[k], hi[k]);
            end
            else
            begin
                qlo[k] = pick_between(lo[k], COORD_MAX);
                qhi[k] = pick_between(COORD_MIN, hi[k]);
            end
        end
        return make_query(qlo[0], qlo[1], qlo[2], qhi[0], qhi[1], qhi[2]);
    endfunction

    // mostly well-formed boxes; the rest near misses, inverted boxes, noise
    function automatic query_t random_query();
        query_t q;
        coord_t swap;
        int     roll;
        roll = $urandom_range(0, 9);
        q = nested_query();
        if (roll == 6)
        begin
            // push one bound out by one; wraps at the range ends
            case ($urandom_range(0, 5))
                0:       q.query_min_x = q.query_min_x - coord_t'(1);
                1:       q.query_min_y = q.query_min_y - coord_t'(1);
                2:       q.query_min_z = q.query_min_z - coord_t'(1);
                3:       q.query_max_x = q.query_max_x + coord_t'(1);
                4:       q.query_max_y = q.query_max_y + coord_t'(1);
                default: q.query_max_z = q.query_max_z + coord_t'(1);
            endcase
        end
        else if (roll == 7)
        begin
            swap = q.query_min_x; q.query_min_x = q.query_max_x; q.query_max_x = swap;
            swap = q.query_min_y; q.query_min_y = q.query_max_y; q.query_max_y = swap;
            swap = q.query_min_z; q.query_min_z = q.query_max_z; q.query_max_z = swap;
        end
        else if (roll >= 8)
            q = query_t'({$urandom, $urandom, $urandom});
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Driving: inputs move on the falling edge, handshakes seen on rising
    // ------------------------------------------------------------------

    // one request; start stays high into the next call when it has no gap
    task automatic send_query(input query_t q);
        int gap;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(10, 40);
        end
        @(negedge clk);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        query <= q;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(locate_node(q));
    endtask

    // stop sending and let every owed result come out of the pipe
    task automatic drain_requests();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // leaves wr_en high; the caller lowers it after its last write
    task automatic write_reg(input logic [REG_INDEX_W-1:0] idx, input coord_t value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        case (idx)
            REG_WORLD_MIN_X: world_lo[0] = value;
            REG_WORLD_MIN_Y: world_lo[1] = value;
            REG_WORLD_MIN_Z: world_lo[2] = value;
            REG_WORLD_MAX_X: world_hi[0] = value;
            REG_WORLD_MAX_Y: world_hi[1] = value;
            REG_WORLD_MAX_Z: world_hi[2] = value;
            default: ;
        endcase
    endtask

    task automatic set_world(input int lx, input int ly, input int lz,
                             input int hx, input int hy, input int hz);
        drain_requests();
        write_reg(REG_WORLD_MIN_X, coord_t'(lx));
        write_reg(REG_WORLD_MIN_Y, coord_t'(ly));
        write_reg(REG_WORLD_MIN_Z, coord_t'(lz));
        write_reg(REG_WORLD_MAX_X, coord_t'(hx));
        write_reg(REG_WORLD_MAX_Y, coord_t'(hy));
        write_reg(REG_WORLD_MAX_Z, coord_t'(hz));
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // random traffic; now and then the sender waits until the pipe is empty
    task automatic random_queries(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 59) == 0)
                drain_requests();
            send_query(random_query());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset world spans the whole range, so every box fits at the root;
    // x splits first at -1, children share the centre coordinate
    task automatic test_reset_world_corners();
        send_query(make_query(COORD_MIN, COORD_MIN, COORD_MIN,
                              COORD_MAX, COORD_MAX, COORD_MAX));
        send_query(make_query(COORD_MIN, COORD_MIN, COORD_MIN,
                              COORD_MIN, COORD_MIN, COORD_MIN));
        send_query(make_query(COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MAX, COORD_MAX));
        send_query(make_query(0, 0, 0, 0, 0, 0));
        // on the shared plane: left child is tried first
        send_query(make_query(-1, -1, -1, -1, -1, -1));
        send_query(make_query(-1, 0, 0, 0, 0, 0));
        // straddles the root split: stays at the root
        send_query(make_query(-2, 0, 0, 0, 0, 0));
        send_query(make_query(COORD_MIN, COORD_MIN, COORD_MIN, -1, COORD_MAX, COORD_MAX));
        // inverted box: held by every node, walks the left spine
        send_query(make_query(COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MIN, COORD_MIN, COORD_MIN));
        random_queries(300);
    endtask

    // small asymmetric world: each bound missed by one, then dropped writes
    task automatic test_root_miss();
        set_world(-1000, -50, 0, 3000, 50, 7);
        send_query(make_query(-1000, -50, 0, 3000, 50, 7));
        send_query(make_query(-1001, -50, 0, 3000, 50, 7));
        send_query(make_query(-1000, -51, 0, 3000, 50, 7));
        send_query(make_query(-1000, -50, -1, 3000, 50, 7));
        send_query(make_query(-1000, -50, 0, 3001, 50, 7));
        send_query(make_query(-1000, -50, 0, 3000, 51, 7));
        send_query(make_query(-1000, -50, 0, 3000, 50, 8));
        send_query(make_query(3000, 50, 7, 3000, 50, 7));
        drain_requests();
        // writes past the register list must leave the world box alone
        write_reg(REG_SPARE_A, coord_t'(16'h7FFF));
        write_reg(REG_SPARE_B, coord_t'(16'h8000));
        @(negedge clk);
        wr_en <= 1'b0;
        send_query(make_query(-1000, -50, 0, 3000, 50, 7));
        send_query(make_query(-1000, -50, 0, 3000, 50, 8));
        random_queries(150);
    endtask

    // y longest, then z longest, then a cube where ties go to x then y
    task automatic test_axis_choice();
        set_world(0, -20000, 0, 10, 20000, 10);
        random_queries(80);
        set_world(-5, -5, COORD_MIN, 5, 5, COORD_MAX);
        random_queries(80);
        set_world(0, 0, 0, 63, 63, 63);
        random_queries(120);
    endtask

    // zero-size world: every split is a tie and both children are the point
    task automatic test_point_world();
        set_world(5, 5, 5, 5, 5, 5);
        random_queries(50);
    endtask

    // min above max: only inverted boxes fit, split rules applied as is
    task automatic test_inverted_world();
        set_world(100, 200, -300, -100, -200, -400);
        random_queries(50);
        set_world(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
        random_queries(50);
    endtask

    task automatic test_random_worlds();
        int lo [3];
        int hi [3];
        int k;
        repeat (4)
        begin
            for (k = 0; k < 3; k++)
            begin
                lo[k] = int'($urandom_range(0, 65535)) + COORD_MIN;
                hi[k] = pick_between(lo[k], COORD_MAX);
            end
            set_world(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
            random_queries(70);
        end
        // back to the full range as the last setting
        set_world(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        random_queries(50);
    endtask

    // ------------------------------------------------------------------
    // Result checking: each done cycle is compared with the oldest lookup
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request", 0, result.node_index);
            else
            begin
                want = pending_results.pop_front();
                if (result.node_index !== want.node_index)
                    report_mismatch("node_index", want.node_index, result.node_index);
                if (result.fits !== want.fits)
                    report_mismatch("fits", want.fits, result.fits);
            end
        end
    end

    // hang detection: nothing taken and nothing produced for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        query          = '0;
        wr_en          = 1'b0;
        wr_index       = '0;
        wr_data        = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        for (int k = 0; k < 3; k++)
        begin
            world_lo[k] = coord_t'(COORD_MIN);
            world_hi[k] = coord_t'(COORD_MAX);
        end
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_world_corners();
        test_root_miss();
        test_axis_choice();
        test_point_world();
        test_inverted_world();
        test_random_worlds();
        drain_requests();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
rtl/ahnl_pkg.sv
rtl/ahnl_split_stage.sv
rtl/aabb_hierarchy_node_locate_core.sv
sim/aabb_hierarchy_node_locate_core_test.sv
